### hdl/hbpg_pkg.sv
`timescale 1ns / 1ps

package hbpg_pkg;

	localparam logic [2:0] FUNC_PERIOD  = 3'd0;
	localparam logic [2:0] FUNC_MATCH   = 3'd1;
	localparam logic [2:0] FUNC_OVERCUR = 3'd2;
	localparam logic [2:0] FUNC_START   = 3'd3;
	localparam logic [2:0] FUNC_STOP    = 3'd4;

	localparam logic [1:0] CFG_DUTY_OFFSET = 2'd0;
	localparam logic [1:0] CFG_DUTY_MIN    = 2'd1;
	localparam logic [1:0] CFG_DUTY_MAX    = 2'd2;

	typedef enum logic [1:0] {
		MODE_DIR0  = 2'd0,
		MODE_DIR1  = 2'd1,
		MODE_BRAKE = 2'd2,
		MODE_HIGHZ = 2'd3
	} mode_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] speed;
		logic       direction;
	} in_t;

	typedef struct packed {
		logic       gate_a_high;
		logic       gate_a_low;
		logic       gate_b_high;
		logic       gate_b_low;
		logic       led_zero;
		logic       led_one;
		logic [7:0] compare_level;
		logic [1:0] active_mode;
	} out_t;

	typedef struct packed {
		logic [7:0] duty_offset;
		logic [7:0] duty_min;
		logic [7:0] duty_max;
	} cfg_t;

endpackage

### hdl/h_bridge_pwm_gate_sequencer_top.sv
`timescale 1ns / 1ps

// H-bridge gate sequencer: each event item (period start, compare match, overcurrent,
// start, stop) gives one result item with the four gate levels, two LED levels, the
// compare duty and the active mode after the update. One item is taken every cycle
// while in_stall is low; an item passes an input register and the result register,
// which loads its result when empty or not stalled. in_stall rises only while the input
// register holds an item and the result register is full and stalled. Configuration is
// to be written by the user only while idle; the block itself does not enforce this.
module h_bridge_pwm_gate_sequencer_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hbpg_pkg::in_t     in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output hbpg_pkg::out_t    out_item,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	hbpg_pkg::in_t  item_s1;
	logic           valid_s1;
	hbpg_pkg::out_t out_q;
	logic           out_valid_q;
	hbpg_pkg::out_t result;
	hbpg_pkg::cfg_t cfg;
	logic           out_free;
	logic           take;

	assign out_free = !out_valid_q || !out_stall;
	assign take     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	hbpg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hbpg_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			item_s1 <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef ASSERT_OFF
	a_no_shoot_through: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.gate_a_high && out_item.gate_a_low) &&
			!(out_item.gate_b_high && out_item.gate_b_low))
		else $error("both switches of one leg on");

	a_brake_no_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.active_mode == hbpg_pkg::MODE_BRAKE |->
			!out_item.gate_a_high && !out_item.gate_b_high)
		else $error("high side on while braking");

	a_stop_high_z: assert property (@(posedge clk) disable iff (!arst_n)
		take && item_s1.func == hbpg_pkg::FUNC_STOP |=>
			out_valid && out_item.active_mode == hbpg_pkg::MODE_HIGHZ)
		else $error("stop did not give high-z");

	a_overcur_off: assert property (@(posedge clk) disable iff (!arst_n)
		take && item_s1.func == hbpg_pkg::FUNC_OVERCUR |=>
			out_valid && !out_item.gate_a_high && !out_item.gate_a_low &&
			!out_item.gate_b_high && !out_item.gate_b_low)
		else $error("overcurrent left a gate on");
`endif

endmodule

### hdl/hbpg_cfg.sv
`timescale 1ns / 1ps

module hbpg_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output hbpg_pkg::cfg_t    cfg
);

	hbpg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty_offset <= 8'd0;
			cfg_q.duty_min    <= 8'd0;
			cfg_q.duty_max    <= 8'hFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hbpg_pkg::CFG_DUTY_OFFSET: cfg_q.duty_offset <= cfg_data;
				hbpg_pkg::CFG_DUTY_MIN:    cfg_q.duty_min    <= cfg_data;
				hbpg_pkg::CFG_DUTY_MAX:    cfg_q.duty_max    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/hbpg_engine.sv
`timescale 1ns / 1ps

module hbpg_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  hbpg_pkg::in_t     item,
	input  hbpg_pkg::cfg_t    cfg,
	output hbpg_pkg::out_t    result
);

	hbpg_pkg::mode_t cur_mode_q, cmd_mode_q, cur_mode_d, cmd_mode_d;
	logic [7:0]      cmd_duty_q, cmp_q, cmd_duty_d, cmp_d;
	logic [3:0]      gates_q, gates_d;
	logic [1:0]      leds_q, leds_d;
	logic [8:0]      sum;
	logic [7:0]      sat;
	logic [7:0]      duty;

	// saturate then clamp, minimum checked first
	always_comb begin
		sum = {1'b0, item.speed} + {1'b0, cfg.duty_offset};
		sat = sum[8] ? 8'hFF : sum[7:0];
		if (sat < cfg.duty_min)
			duty = cfg.duty_min;
		else if (sat > cfg.duty_max)
			duty = cfg.duty_max;
		else
			duty = sat;
	end

	// gates ordered a_high, a_low, b_high, b_low; leds ordered zero, one
	always_comb begin
		cur_mode_d = cur_mode_q;
		cmd_mode_d = cmd_mode_q;
		cmd_duty_d = cmd_duty_q;
		cmp_d      = cmp_q;
		gates_d    = gates_q;
		leds_d     = leds_q;
		case (item.func)
			hbpg_pkg::FUNC_PERIOD: begin
				cur_mode_d = cmd_mode_q;
				cmp_d      = cmd_duty_q;
				unique case (cmd_mode_q)
					hbpg_pkg::MODE_DIR0: begin
						gates_d = 4'b1001;
						leds_d  = 2'b10;
					end
					hbpg_pkg::MODE_DIR1: begin
						gates_d = 4'b0110;
						leds_d  = 2'b01;
					end
					hbpg_pkg::MODE_BRAKE: begin
						gates_d = 4'b0101;
						leds_d  = 2'b00;
					end
					default: begin
						gates_d = 4'b0000;
						leds_d  = 2'b11;
					end
				endcase
			end
			hbpg_pkg::FUNC_MATCH: begin
				if (cur_mode_q == hbpg_pkg::MODE_DIR0) begin
					gates_d[3:2] = 2'b01;
					leds_d       = 2'b00;
				end else if (cur_mode_q == hbpg_pkg::MODE_DIR1) begin
					gates_d[1:0] = 2'b01;
					leds_d       = 2'b00;
				end
			end
			hbpg_pkg::FUNC_OVERCUR: begin
				gates_d    = 4'b0000;
				cur_mode_d = hbpg_pkg::MODE_HIGHZ;
			end
			hbpg_pkg::FUNC_START: begin
				if (item.speed == 8'd0) begin
					cmd_mode_d = hbpg_pkg::MODE_BRAKE;
					cmd_duty_d = 8'd0;
				end else begin
					cmd_mode_d = item.direction ? hbpg_pkg::MODE_DIR1 : hbpg_pkg::MODE_DIR0;
					cmd_duty_d = duty;
				end
			end
			hbpg_pkg::FUNC_STOP: begin
				cmd_mode_d = hbpg_pkg::MODE_HIGHZ;
				cur_mode_d = hbpg_pkg::MODE_HIGHZ;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode_q <= hbpg_pkg::MODE_HIGHZ;
			cmd_mode_q <= hbpg_pkg::MODE_HIGHZ;
			cmd_duty_q <= 8'd0;
			cmp_q      <= 8'd0;
			gates_q    <= 4'b0000;
			leds_q     <= 2'b00;
		end else if (take) begin
			cur_mode_q <= cur_mode_d;
			cmd_mode_q <= cmd_mode_d;
			cmd_duty_q <= cmd_duty_d;
			cmp_q      <= cmp_d;
			gates_q    <= gates_d;
			leds_q     <= leds_d;
		end
	end

	always_comb begin
		result.gate_a_high   = gates_d[3];
		result.gate_a_low    = gates_d[2];
		result.gate_b_high   = gates_d[1];
		result.gate_b_low    = gates_d[0];
		result.led_zero      = leds_d[1];
		result.led_one       = leds_d[0];
		result.compare_level = cmp_d;
		result.active_mode   = cur_mode_d;
	end

endmodule

### sim/h_bridge_pwm_gate_sequencer_top_tb.sv
`timescale 1ns / 1ps

class gate_scoreboard;
	logic [7:0] duty_offset;
	logic [7:0] duty_min;
	logic [7:0] duty_max;
	hbpg_pkg::mode_t run_mode;
	hbpg_pkg::mode_t req_mode;
	logic [7:0] req_duty;
	logic [7:0] compare;
	logic a_high, a_low, b_high, b_low;
	logic led0, led1;
	hbpg_pkg::out_t pending[$];
	int errors;

	function new();
		duty_offset = 8'd0;
		duty_min = 8'd0;
		duty_max = 8'd255;
		run_mode = hbpg_pkg::MODE_HIGHZ;
		req_mode = hbpg_pkg::MODE_HIGHZ;
		req_duty = 8'd0;
		compare = 8'd0;
		{a_high, a_low, b_high, b_low} = 4'b0000;
		{led0, led1} = 2'b00;
		errors = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [7:0] val);
		case (idx)
			hbpg_pkg::CFG_DUTY_OFFSET: duty_offset = val;
			hbpg_pkg::CFG_DUTY_MIN: duty_min = val;
			hbpg_pkg::CFG_DUTY_MAX: duty_max = val;
			default: ;
		endcase
	endfunction

	function void note_event(hbpg_pkg::in_t ev);
		int duty;
		hbpg_pkg::out_t res;
		case (ev.func)
			hbpg_pkg::FUNC_PERIOD: begin
				run_mode = req_mode;
				compare = req_duty;
				case (run_mode)
					hbpg_pkg::MODE_DIR0: begin
						{a_high, a_low, b_high, b_low} = 4'b1001;
						{led0, led1} = 2'b10;
					end
					hbpg_pkg::MODE_DIR1: begin
						{a_high, a_low, b_high, b_low} = 4'b0110;
						{led0, led1} = 2'b01;
					end
					hbpg_pkg::MODE_BRAKE: begin
						{a_high, a_low, b_high, b_low} = 4'b0101;
						{led0, led1} = 2'b00;
					end
					default: begin
						{a_high, a_low, b_high, b_low} = 4'b0000;
						{led0, led1} = 2'b11;
					end
				endcase
			end
			hbpg_pkg::FUNC_MATCH: begin
				if (run_mode == hbpg_pkg::MODE_DIR0) begin
					a_high = 1'b0;
					a_low = 1'b1;
					{led0, led1} = 2'b00;
				end else if (run_mode == hbpg_pkg::MODE_DIR1) begin
					b_high = 1'b0;
					b_low = 1'b1;
					{led0, led1} = 2'b00;
				end
			end
			hbpg_pkg::FUNC_OVERCUR: begin
				{a_high, a_low, b_high, b_low} = 4'b0000;
				run_mode = hbpg_pkg::MODE_HIGHZ;
			end
			hbpg_pkg::FUNC_START: begin
				if (ev.speed == 8'd0) begin
					req_mode = hbpg_pkg::MODE_BRAKE;
					req_duty = 8'd0;
				end else begin
					duty = int'(ev.speed) + int'(duty_offset);
					if (duty > 255)
						duty = 255;
					if (duty < int'(duty_min))
						duty = int'(duty_min);
					else if (duty > int'(duty_max))
						duty = int'(duty_max);
					req_mode = ev.direction ? hbpg_pkg::MODE_DIR1 : hbpg_pkg::MODE_DIR0;
					req_duty = duty[7:0];
				end
			end
			hbpg_pkg::FUNC_STOP: begin
				req_mode = hbpg_pkg::MODE_HIGHZ;
				run_mode = hbpg_pkg::MODE_HIGHZ;
			end
			default: ;
		endcase
		res.gate_a_high = a_high;
		res.gate_a_low = a_low;
		res.gate_b_high = b_high;
		res.gate_b_low = b_low;
		res.led_zero = led0;
		res.led_one = led1;
		res.compare_level = compare;
		res.active_mode = run_mode;
		pending.push_back(res);
	endfunction

	function void check_field(string name, logic [7:0] exp, logic [7:0] act);
		if (exp !== act) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, exp, act);
		end
	endfunction

	function void check_result(hbpg_pkg::out_t got);
		hbpg_pkg::out_t exp;
		if (pending.size() == 0) begin
			errors++;
			$display("%0t: unexpected result item, expected none actual %h", $time, got);
			return;
		end
		exp = pending.pop_front();
		check_field("gate_a_high", 8'(exp.gate_a_high), 8'(got.gate_a_high));
		check_field("gate_a_low", 8'(exp.gate_a_low), 8'(got.gate_a_low));
		check_field("gate_b_high", 8'(exp.gate_b_high), 8'(got.gate_b_high));
		check_field("gate_b_low", 8'(exp.gate_b_low), 8'(got.gate_b_low));
		check_field("led_zero", 8'(exp.led_zero), 8'(got.led_zero));
		check_field("led_one", 8'(exp.led_one), 8'(got.led_one));
		check_field("compare_level", exp.compare_level, got.compare_level);
		check_field("active_mode", 8'(exp.active_mode), 8'(got.active_mode));
	endfunction
endclass

module h_bridge_pwm_gate_sequencer_top_tb;
	import hbpg_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_item;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_item;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	gate_scoreboard sb;
	bit idling_on = 1'b1;
	int quiet_cycles = 0;

	h_bridge_pwm_gate_sequencer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && !out_stall)
			sb.check_result(out_item);
		out_stall <= idling_on && ($urandom_range(0, 99) < 34);
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (in_valid && in_stall === 1'b0)
				|| (out_valid === 1'b1 && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("h_bridge_pwm_gate_sequencer_top: mismatch");
			$finish;
		end
	end

	task automatic send_event(input in_t ev);
		while (idling_on && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= ev;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		sb.note_event(ev);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input logic [7:0] offset, input logic [7:0] dmin,
			input logic [7:0] dmax);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_DUTY_OFFSET;
		cfg_data <= offset;
		sb.set_reg(CFG_DUTY_OFFSET, offset);
		@(posedge clk);
		cfg_index <= CFG_DUTY_MIN;
		cfg_data <= dmin;
		sb.set_reg(CFG_DUTY_MIN, dmin);
		@(posedge clk);
		cfg_index <= CFG_DUTY_MAX;
		cfg_data <= dmax;
		sb.set_reg(CFG_DUTY_MAX, dmax);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_speed();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic run_random(input int count);
		int sent;
		int pick;
		in_t ev;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 75) begin
				if ($urandom_range(0, 99) < 60) begin
					send_event(in_t'{FUNC_START, pick_speed(), 1'($urandom_range(0, 1))});
					sent++;
				end
				send_event(in_t'{FUNC_PERIOD, 8'($urandom), 1'($urandom_range(0, 1))});
				sent++;
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					send_event(in_t'{FUNC_OVERCUR, 8'($urandom), 1'($urandom_range(0, 1))});
					sent++;
				end else if (pick < 14) begin
					send_event(in_t'{FUNC_STOP, 8'($urandom), 1'($urandom_range(0, 1))});
					sent++;
				end
				if ($urandom_range(0, 99) < 70) begin
					send_event(in_t'{FUNC_MATCH, 8'($urandom), 1'($urandom_range(0, 1))});
					sent++;
				end
			end else begin
				ev = in_t'(12'($urandom));
				send_event(ev);
				if (ev.func <= FUNC_STOP)
					sent++;
			end
		end
	endtask

	initial begin
		logic [7:0] phase_cfg [0:8][0:2];
		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_DUTY_OFFSET;
		cfg_data <= 8'd0;
		phase_cfg = '{
			'{8'd0, 8'd0, 8'd255},
			'{8'd255, 8'd0, 8'd255},
			'{8'd200, 8'd50, 8'd100},
			'{8'd100, 8'd200, 8'd50},
			'{8'd0, 8'd0, 8'd0},
			'{8'd255, 8'd255, 8'd255},
			'{8'd0, 8'd255, 8'd0},
			'{8'd30, 8'd20, 8'd240},
			'{8'd7, 8'd90, 8'd160}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration, walk the modes and their special cases
		send_event(in_t'{FUNC_PERIOD, 8'd0, 1'b0});
		send_event(in_t'{FUNC_MATCH, 8'd0, 1'b0});
		send_event(in_t'{FUNC_START, 8'd0, 1'b1});
		send_event(in_t'{FUNC_PERIOD, 8'd255, 1'b1});
		send_event(in_t'{FUNC_MATCH, 8'd0, 1'b0});
		send_event(in_t'{FUNC_START, 8'd255, 1'b0});
		send_event(in_t'{FUNC_PERIOD, 8'd0, 1'b0});
		send_event(in_t'{FUNC_MATCH, 8'd0, 1'b0});
		send_event(in_t'{FUNC_OVERCUR, 8'd0, 1'b0});
		send_event(in_t'{FUNC_MATCH, 8'd0, 1'b0});
		send_event(in_t'{FUNC_START, 8'd1, 1'b1});
		send_event(in_t'{FUNC_PERIOD, 8'd0, 1'b0});
		send_event(in_t'{FUNC_MATCH, 8'd255, 1'b1});
		send_event(in_t'{FUNC_STOP, 8'd0, 1'b0});
		send_event(in_t'{FUNC_PERIOD, 8'd0, 1'b0});
		send_event(in_t'{3'd5, 8'd255, 1'b1});
		send_event(in_t'{3'd6, 8'd0, 1'b0});
		send_event(in_t'{3'd7, 8'd255, 1'b1});
		send_event(in_t'{FUNC_START, 8'd128, 1'b1});
		send_event(in_t'{FUNC_PERIOD, 8'd0, 1'b0});
		send_event(in_t'{FUNC_STOP, 8'd0, 1'b0});
		send_event(in_t'{FUNC_MATCH, 8'd0, 1'b0});
		send_event(in_t'{FUNC_PERIOD, 8'd0, 1'b0});

		for (int p = 0; p < 9; p++) begin
			load_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
			// one phase with both sides running flat out
			idling_on = (p != 2);
			run_random(145);
		end

		drain();
		if (sb.errors == 0)
			$display("h_bridge_pwm_gate_sequencer_top: match");
		else
			$display("h_bridge_pwm_gate_sequencer_top: mismatch");
		$finish;
	end
endmodule

### files.f
hdl/hbpg_pkg.sv
hdl/hbpg_cfg.sv
hdl/hbpg_engine.sv
hdl/h_bridge_pwm_gate_sequencer_top.sv
sim/h_bridge_pwm_gate_sequencer_top_tb.sv
